@@ hdl/qdv_pkg.sv @@
// shared types and constants for the quadrature decoder velocity core
`default_nettype none

package qdv_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_QUERY  = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned SCALE_W = 20;
    // |delta| * 1e6 stays below 2^51
    localparam int unsigned PROD_W  = 51;
    localparam int unsigned STEP_W  = 6;

    localparam logic [SCALE_W-1:0] US_PER_SEC = SCALE_W'(1000000);

    typedef struct packed {
        op_t         opcode;
        logic        level_a;
        logic        level_b;
        logic [31:0] time_us;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] tick_count;
        logic signed [31:0] velocity;
        logic               velocity_valid;
    } out_item_t;

endpackage

`default_nettype wire

@@ hdl/quadrature_decoder_velocity_core.sv @@
// top level: x4 quadrature position counter with velocity estimate
`default_nettype none

// Each input item is an edge on channel A or B, a velocity query or a count
// reset, and every item gives exactly one result item. For edge and reset
// items the result is registered in the cycle after the item is accepted. A
// velocity query with nonzero elapsed time captures the position delta and
// elapsed time, multiplies by 1e6, runs the restoring divider that retires
// one quotient bit per cycle, and then saturates and delivers once the output
// register is free. From the multiply until delivery the input stalls. The
// output register holds a finished result until it is taken, and a new item
// is accepted in the same cycle the old result leaves.
// Velocity is ticks per second, truncated toward zero and saturated to
// signed 32 bits; a query with zero elapsed time returns velocity 0 with
// velocity_valid low and leaves the stored snapshot alone.
module quadrature_decoder_velocity_core
    import qdv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    state_t state_reg, state_next;

    // architectural state
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] snap_cnt_reg, snap_cnt_next;
    logic [CNT_W-1:0] snap_time_reg, snap_time_next;

    // divide datapath
    logic [CNT_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  dt_reg, dt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic in_fire;
    logic out_fire;
    logic out_free;

    logic [CNT_W-1:0] dt_now;
    logic [CNT_W-1:0] delta_now;
    logic             same_lvl;

    logic [CNT_W+SCALE_W-1:0] prod;
    logic [CNT_W:0]           rem_shift;
    logic [CNT_W+1:0]         trial;
    logic [CNT_W-1:0]         vel_sat;
    logic                     div_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign dt_now    = in_data.time_us - snap_time_reg;
    assign delta_now = pos_reg - snap_cnt_reg;
    assign same_lvl  = (in_data.level_a == in_data.level_b);

    // one multiply per query, registered before the divider
    assign prod = {{SCALE_W{1'b0}}, mag_reg} * {{CNT_W{1'b0}}, US_PER_SEC};

    // restoring divide step: shift in the next dividend bit, try subtract
    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dt_reg};
    assign div_last  = (step_reg == STEP_W'(PROD_W - 1));

    // saturate the magnitude quotient and restore the sign
    always_comb
    begin
        if (!neg_reg)
        begin
            if (|quo_reg[PROD_W-1:CNT_W-1])
                vel_sat = {1'b0, {(CNT_W-1){1'b1}}};
            else
                vel_sat = quo_reg[CNT_W-1:0];
        end
        else
        begin
            // beyond 2^31 clips to the most negative value
            if ((|quo_reg[PROD_W-1:CNT_W]) || (quo_reg[CNT_W-1] && |quo_reg[CNT_W-2:0]))
                vel_sat = {1'b1, {(CNT_W-1){1'b0}}};
            else
                vel_sat = CNT_W'(0) - quo_reg[CNT_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.opcode == OP_QUERY && dt_now != '0)
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and result outputs
    always_comb
    begin
        pos_next       = pos_reg;
        snap_cnt_next  = snap_cnt_reg;
        snap_time_next = snap_time_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        dt_next        = dt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_data_next.velocity       = '0;
                    out_data_next.velocity_valid = 1'b0;
                    out_valid_next               = 1'b1;
                    case (in_data.opcode)
                        OP_EDGE_A:
                            pos_next = same_lvl ? pos_reg - CNT_W'(1) : pos_reg + CNT_W'(1);
                        OP_EDGE_B:
                            pos_next = same_lvl ? pos_reg + CNT_W'(1) : pos_reg - CNT_W'(1);
                        OP_QUERY:
                        begin
                            if (dt_now != '0)
                            begin
                                // result comes out of the divider later
                                out_valid_next = out_fire ? 1'b0 : out_valid_reg;
                                neg_next       = delta_now[CNT_W-1];
                                mag_next       = delta_now[CNT_W-1] ?
                                                 CNT_W'(0) - delta_now : delta_now;
                                dt_next        = dt_now;
                                snap_cnt_next  = pos_reg;
                                snap_time_next = in_data.time_us;
                            end
                        end
                        OP_RESET:
                        begin
                            pos_next       = '0;
                            snap_cnt_next  = '0;
                            snap_time_next = in_data.time_us;
                        end
                        default:
                            pos_next = pos_reg;
                    endcase
                    out_data_next.tick_count = pos_next;
                end
            end
            ST_MUL:
            begin
                quo_next  = prod[PROD_W-1:0];
                rem_next  = '0;
                step_next = '0;
            end
            ST_DIV:
            begin
                if (!trial[CNT_W+1])
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[CNT_W-1:0];
                    quo_next = {quo_reg[PROD_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next.tick_count     = pos_reg;
                    out_data_next.velocity       = vel_sat;
                    out_data_next.velocity_valid = 1'b1;
                    out_valid_next               = 1'b1;
                end
            end
            default:
                out_valid_next = out_valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            snap_cnt_reg  <= '0;
            snap_time_reg <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            snap_cnt_reg  <= snap_cnt_next;
            snap_time_reg <= snap_time_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        dt_reg       <= dt_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ tb/quadrature_decoder_velocity_core_test.sv @@
// self-checking testbench for the quadrature decoder velocity core
`timescale 1ns / 1ps

module quadrature_decoder_velocity_core_test
    import qdv_pkg::*;
;

    // cycles with no item moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 3000;
    // one long receiver hold that backs the block up into its input
    localparam int LONG_HOLD = 400;
    // settle time after the last result
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1900;
    localparam longint VEL_MAX = 64'sd2147483647;
    localparam longint VEL_MIN = -64'sd2147483648;

    typedef struct {
        in_item_t item;
        bit       drain_first; // hold this item back until no result is owed
    } queued_item_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // stimulus and scoreboard
    queued_item_t pending_items[$];
    out_item_t    expected_results[$];
    int           items_in = 0;
    int           total_items = 0;
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           in_taken = 1'b0;
    bit           out_taken;
    out_item_t    oldest;

    // encoder state as the predictor sees it
    logic [31:0] position;
    logic [31:0] snap_count;
    logic [31:0] snap_time;

    // generator's own view of the snapshot time, so queries can hit dt = 0
    logic [31:0] gen_snap_time;

    // sender and receiver pacing
    int tx_wait = 0;
    int tx_run = 0;
    bit tx_quiet = 1'b1;
    int rx_wait = 0;
    int rx_run = 0;
    bit rx_quiet = 1'b0;
    int hold_left = 0;
    bit held_once = 1'b0;
    queued_item_t next_item;

    quadrature_decoder_velocity_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // ticks per second: signed delta times 1e6 over unsigned dt, truncated
    // toward zero, then clamped to the signed 32-bit range
    function automatic logic signed [31:0] ticks_per_sec(logic [31:0] delta,
                                                         logic [31:0] dt);
        longint num;
        longint quo;
        num = longint'($signed(delta)) * longint'(US_PER_SEC);
        quo = num / longint'({32'd0, dt});
        if (quo > VEL_MAX)
            quo = VEL_MAX;
        else if (quo < VEL_MIN)
            quo = VEL_MIN;
        return quo[31:0];
    endfunction

    // apply one item to the encoder state and return the result it causes
    function automatic out_item_t advance_encoder(in_item_t it);
        out_item_t   res;
        logic [31:0] dt;
        res = '0;
        case (it.opcode)
            OP_EDGE_A:
            begin
                // A edge: equal levels count down
                if (it.level_a == it.level_b)
                    position = position - 32'd1;
                else
                    position = position + 32'd1;
            end
            OP_EDGE_B:
            begin
                // B edge: the sense is flipped
                if (it.level_a == it.level_b)
                    position = position + 32'd1;
                else
                    position = position - 32'd1;
            end
            OP_QUERY:
            begin
                dt = it.time_us - snap_time;
                // zero elapsed time leaves the snapshot alone
                if (dt != 32'd0)
                begin
                    res.velocity = ticks_per_sec(position - snap_count, dt);
                    res.velocity_valid = 1'b1;
                    snap_count = position;
                    snap_time = it.time_us;
                end
            end
            default:
            begin
                position = '0;
                snap_count = '0;
                snap_time = it.time_us;
            end
        endcase
        res.tick_count = position;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(op_t op, logic a, logic b, logic [31:0] t,
                             bit drain = 1'b0);
        queued_item_t q;
        q.item.opcode = op;
        q.item.level_a = a;
        q.item.level_b = b;
        q.item.time_us = t;
        q.drain_first = drain;
        pending_items.push_back(q);
        // keep track of where the block's snapshot time will be
        if (op == OP_RESET || (op == OP_QUERY && t != gen_snap_time))
            gen_snap_time = t;
    endtask

    // one edge in a chosen direction with random channel and levels
    task automatic push_step(bit up);
        op_t  op;
        logic a;
        logic b;
        op = $urandom_range(0, 1) ? OP_EDGE_B : OP_EDGE_A;
        a = 1'($urandom_range(0, 1));
        if (op == OP_EDGE_A)
            b = up ? ~a : a;
        else
            b = up ? a : ~a;
        push_item(op, a, b, $urandom);
    endtask

    // elapsed time for a query: mostly short, some zero, some wrapping
    function automatic logic [31:0] pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 65)
            return $urandom_range(1, 1000);
        if (r < 88)
            return $urandom_range(1, 1 << 20);
        return $urandom;
    endfunction

    // pause length for either side; alternates noisy and quiet stretches
    function automatic int pick_pause(inout bit quiet, inout int run_left);
        int r;
        if (run_left == 0)
        begin
            quiet = !quiet;
            run_left = $urandom_range(100, 400);
        end
        run_left--;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // driver: new item or a gap at each falling edge once the last is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain_first && expected_results.size() > 0))
            begin
                next_item = pending_items.pop_front();
                in_data <= next_item.item;
                in_valid <= 1'b1;
                tx_wait = pick_pause(tx_quiet, tx_run);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus one long hold early in the run
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rst_n && !held_once && items_in >= 60)
        begin
            held_once = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
        begin
            rx_wait = pick_pause(rx_quiet, rx_run);
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            out_taken = out_valid && !out_stall;
            // check before predicting so a result can never match the item
            // taken at the same edge
            if (out_taken)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: tick_count %0d velocity %0d valid %0b",
                           out_data.tick_count, out_data.velocity,
                           out_data.velocity_valid);
                    error_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (out_data.tick_count !== oldest.tick_count)
                    begin
                        $error("tick_count: expected %0d, got %0d",
                               oldest.tick_count, out_data.tick_count);
                        error_count++;
                    end
                    if (out_data.velocity !== oldest.velocity)
                    begin
                        $error("velocity: expected %0d, got %0d",
                               oldest.velocity, out_data.velocity);
                        error_count++;
                    end
                    if (out_data.velocity_valid !== oldest.velocity_valid)
                    begin
                        $error("velocity_valid: expected %0b, got %0b",
                               oldest.velocity_valid, out_data.velocity_valid);
                        error_count++;
                    end
                end
            end
            if (in_taken)
            begin
                expected_results.push_back(advance_encoder(in_data));
                items_in++;
            end
            // watchdog on handshake progress
            if (in_taken || out_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int          n;
        int          k;
        int          r;
        logic [31:0] dt;
        position = '0;
        snap_count = '0;
        snap_time = '0;
        gen_snap_time = '0;

        // directed: every operation and level pair, the zero-dt query,
        // truncation toward zero, timestamp wrap, ignored fields
        push_item(OP_RESET, 1'b1, 1'b0, 32'h0000_0010);
        push_item(OP_EDGE_A, 1'b0, 1'b0, 32'hFFFF_FFFF);
        push_item(OP_EDGE_A, 1'b0, 1'b1, 32'h0000_0000);
        push_item(OP_EDGE_A, 1'b1, 1'b0, 32'hA5A5_5A5A);
        push_item(OP_EDGE_A, 1'b1, 1'b1, 32'h5A5A_A5A5);
        push_item(OP_EDGE_B, 1'b0, 1'b0, 32'h0000_0001);
        push_item(OP_EDGE_B, 1'b0, 1'b1, 32'h8000_0000);
        push_item(OP_EDGE_B, 1'b1, 1'b0, 32'h7FFF_FFFF);
        push_item(OP_EDGE_B, 1'b1, 1'b1, 32'h0000_0000);
        push_item(OP_QUERY, 1'b1, 1'b1, 32'h0000_0010);
        push_item(OP_EDGE_A, 1'b0, 1'b1, 32'h0);
        push_item(OP_EDGE_A, 1'b1, 1'b0, 32'h0);
        push_item(OP_EDGE_B, 1'b1, 1'b1, 32'h0);
        push_item(OP_QUERY, 1'b0, 1'b1, 32'h0000_0017);
        push_item(OP_EDGE_B, 1'b1, 1'b0, 32'h0);
        push_item(OP_EDGE_A, 1'b0, 1'b0, 32'h0);
        push_item(OP_QUERY, 1'b1, 1'b0, 32'h0000_001A);
        push_item(OP_RESET, 1'b1, 1'b1, 32'hFFFF_FFF0);
        push_item(OP_EDGE_A, 1'b1, 1'b0, 32'h0);
        push_item(OP_QUERY, 1'b0, 1'b0, 32'h0000_0010);
        push_item(OP_RESET, 1'b0, 1'b0, 32'hFFFF_FFFF);
        push_item(OP_QUERY, 1'b0, 1'b0, 32'h0000_0000);
        push_item(OP_EDGE_B, 1'b0, 1'b0, 32'h0);
        push_item(OP_QUERY, 1'b1, 1'b1, 32'hFFFF_FFFF);

        // random: mostly runs of edges closed by a query, some resets,
        // some noise, some steady bursts for large rates
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                k = $urandom_range(0, 12);
                repeat (k)
                    push_item(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom);
                // drain pauses at the first query and in a window midway
                push_item(OP_QUERY, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          gen_snap_time + pick_dt(),
                          n == 0 || (n >= RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 14));
                n += k + 1;
            end
            else if (r < 80)
            begin
                push_item(OP_RESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom);
                n++;
            end
            else if (r < 90)
            begin
                push_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom);
                n++;
            end
            else
            begin
                k = $urandom_range(20, 60);
                r = $urandom_range(0, 1);
                repeat (k)
                    push_step(r[0]);
                dt = $urandom_range(1, 50);
                push_item(OP_QUERY, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          gen_snap_time + dt);
                n += k + 1;
            end
        end

        // close with a query at zero elapsed time
        push_item(OP_QUERY, 1'b0, 1'b0, gen_snap_time);

        total_items = pending_items.size();

        // hold reset, then release it on a falling edge
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // wait for every item to go in and every result to come back
        while (items_in < total_items || expected_results.size() > 0)
            @(negedge clk);
        // let any stray result show up
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/qdv_pkg.sv
hdl/quadrature_decoder_velocity_core.sv
tb/quadrature_decoder_velocity_core_test.sv
